@@ sv/ipb_pkg.sv @@
// shared types, constants and helpers for the instruction prefetch buffer
// no dependencies; used by ipb_next, instruction_prefetch_buffer and the testbench files
`default_nettype none

package ipb_pkg;

	localparam int BUF_DEPTH = 8;
	localparam int WORD_W    = 32;
	localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
	localparam int IDX_W     = $clog2(BUF_DEPTH);

	// fetch restarts at 0x100, so entry 0 holds the word before it
	localparam logic [WORD_W-1:0] ADDR_RESTART = 32'h0000_00FC;
	localparam logic [WORD_W-1:0] ADDR_STEP    = 32'h0000_0004;

	// opcodes that redirect fetch
	localparam logic [5:0] OP_BRANCH_LAST = 6'h04;
	localparam logic [5:0] OP_JR          = 6'h08;
	localparam logic [5:0] OP_JALR        = 6'h09;
	localparam logic [5:0] OP_MTHI        = 6'h11;
	localparam logic [5:0] OP_MFLO        = 6'h12;

	typedef struct packed {
		logic              advance;
		logic              take_jump;
		logic [WORD_W-1:0] jump_target;
		logic              mem_ack;
		logic [WORD_W-1:0] mem_data;
		logic              restart;
	} fetch_item_t;

	typedef struct packed {
		logic              read_request;
		logic [WORD_W-1:0] read_address;
		logic [WORD_W-1:0] current_insn;
		logic              insn_valid;
		logic [WORD_W-1:0] prev_pc;
		logic [WORD_W-1:0] cur_pc;
		logic [WORD_W-1:0] next_pc;
		logic              next_pc_valid;
	} status_item_t;

	typedef struct packed {
		logic [BUF_DEPTH-1:0][WORD_W-1:0] insn;
		logic [BUF_DEPTH-1:0][WORD_W-1:0] addr;
		logic [FILL_W-1:0]                insn_fill;
		logic [FILL_W-1:0]                addr_fill;
		logic                             ack_d;
		logic [WORD_W-1:0]                held_addr;
	} ipb_state_t;

	// state after reset: one entry in each buffer, address entry 0 at the restart word
	localparam ipb_state_t STATE_RESET = '{
		insn:      '0,
		addr:      (BUF_DEPTH*WORD_W)'(ADDR_RESTART),
		insn_fill: FILL_W'(1),
		addr_fill: FILL_W'(1),
		ack_d:     1'b0,
		held_addr: '0
	};

	function automatic logic is_jump_op(input logic [WORD_W-1:0] w);
		logic [5:0] op;
		op = w[WORD_W-1:WORD_W-6];
		return op inside {[6'h00:OP_BRANCH_LAST], OP_JR, OP_JALR, OP_MTHI, OP_MFLO};
	endfunction

endpackage

`default_nettype wire

@@ sv/ipb_next.sv @@
// next-state and result logic for one fetch cycle of the prefetch buffer
// depends on ipb_pkg
`default_nettype none

module ipb_next
	import ipb_pkg::*;
(
	input  wire  ipb_state_t   cur,
	input  wire  fetch_item_t  item,
	output ipb_state_t         nxt,
	output status_item_t       res
);

	always_comb begin
		logic [FILL_W-1:0] it;
		logic [FILL_W-1:0] at;
		logic [IDX_W-1:0]  src;
		logic [FILL_W:0]   nit;
		logic [FILL_W:0]   ridx;
		logic [FILL_W:0]   jidx;
		logic              read;
		ipb_state_t        n;

		n      = cur;
		n.ack_d = item.mem_ack;
		read   = 1'b0;
		it     = cur.insn_fill;
		at     = cur.addr_fill;
		src    = '0;

		// shift both buffers; top entry keeps its old value
		if (item.advance) begin
			for (int k = 0; k < BUF_DEPTH - 1; k++) begin
				n.insn[k] = cur.insn[k+1];
				n.addr[k] = cur.addr[k+1];
			end
			if (it != '0) it = it - 1'b1;
			if (at != '0) at = at - 1'b1;
		end

		// extend address buffer by last address plus 4
		if (at < FILL_W'(BUF_DEPTH)) begin
			if (item.advance)
				src = at[IDX_W-1:0];
			else if (at != '0)
				src = IDX_W'(at - 1'b1);
			n.addr[at[IDX_W-1:0]] = cur.addr[src] + ADDR_STEP;
			at = at + 1'b1;
		end

		// jump: keep delay slot, redirect entry 2
		if (item.take_jump) begin
			if (it > FILL_W'(2)) it = FILL_W'(2);
			n.addr[2] = item.jump_target;
			at = FILL_W'(3);
		end

		// store word acked with the previous accepted item, drop it when full
		if (cur.ack_d && it < FILL_W'(BUF_DEPTH)) begin
			n.insn[it[IDX_W-1:0]] = item.mem_data;
			it = it + 1'b1;
		end

		nit  = {1'b0, it} + (FILL_W+1)'(item.mem_ack);
		ridx = nit + (FILL_W+1)'(item.advance);
		jidx = ridx - (FILL_W+1)'(2);
		if ({1'b0, at} > nit && ridx < (FILL_W+1)'(BUF_DEPTH)
				&& !(nit >= (FILL_W+1)'(2) && is_jump_op(cur.insn[jidx[IDX_W-1:0]]))) begin
			n.held_addr = cur.addr[ridx[IDX_W-1:0]];
			read = 1'b1;
		end

		if (item.restart) begin
			it        = FILL_W'(1);
			at        = FILL_W'(1);
			n.addr[0] = ADDR_RESTART;
			read      = 1'b0;
		end

		n.insn_fill = it;
		n.addr_fill = at;
		nxt = n;

		res.read_request  = read;
		res.read_address  = n.held_addr;
		res.current_insn  = n.insn[1];
		res.insn_valid    = (it > FILL_W'(1));
		res.prev_pc       = n.addr[0];
		res.cur_pc        = n.addr[1];
		res.next_pc       = n.addr[2];
		res.next_pc_valid = (at > FILL_W'(2));
	end

endmodule

`default_nettype wire

@@ sv/instruction_prefetch_buffer.sv @@
// top level of the instruction prefetch buffer: state register and result skid buffer
// depends on ipb_pkg and ipb_next
//
// usage:
//  - fetch channel (fetch_valid / fetch_stall / fetch): one item is one clock of the
//    fetch unit: advance, jump request and target, memory ack and data, restart
//  - status channel (status_valid / status_stall / status): one item per accepted
//    fetch item: read request and address, current instruction, pc window, valid flags
//  - the result is registered, in the output register or in the skid entry behind it
//  - throughput: one item per cycle while fetch_stall is low; all work for an item is one
//    combinational pass from the buffer registers into the state and result registers
//  - a two-entry result buffer (output register plus skid) lets a new item in while a
//    finished result still waits; fetch_stall rises only when both entries are full
//  - fetch_stall comes from a register, so it never depends on status_stall directly
//  - arst_n clears the fill levels to one, the pending ack and the held read address,
//    and sets address entry 0 to 0xfc; no result is pending after reset
//  - the restart field does the same for fill levels and entry 0 in-band, while the
//    other effects of that item still take place, except that its read request is dropped
`default_nettype none

module instruction_prefetch_buffer
	import ipb_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           fetch_valid,
	output logic          fetch_stall,
	input  wire  fetch_item_t  fetch,
	output logic          status_valid,
	input  wire           status_stall,
	output status_item_t  status
);

	ipb_state_t   state_q;
	ipb_state_t   state_nxt;
	status_item_t res_nxt;

	status_item_t out_q;
	logic         out_valid_q;
	status_item_t skid_q;
	logic         skid_valid_q;

	logic accept;
	logic taken;

	assign fetch_stall  = skid_valid_q;
	assign accept       = fetch_valid && !skid_valid_q;
	assign taken        = out_valid_q && !status_stall;
	assign status_valid = out_valid_q;
	assign status       = out_q;

	ipb_next u_next (
		.cur  (state_q),
		.item (fetch),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// buffer state advances only on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (taken) begin
				if (skid_valid_q)
					skid_valid_q <= 1'b0;
				else
					out_valid_q <= accept;
			end else if (accept) begin
				if (out_valid_q)
					skid_valid_q <= 1'b1;
				else
					out_valid_q <= 1'b1;
			end
		end
	end

	// result payload: skid drains first, new result lands where there is room
	always_ff @(posedge clk) begin
		if (taken) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res_nxt;
		end else if (accept) begin
			if (out_valid_q)
				skid_q <= res_nxt;
			else
				out_q <= res_nxt;
		end
	end

	// skid entry is only ever used behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	// fill levels stay within the buffer
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.insn_fill <= FILL_W'(BUF_DEPTH)) && (state_q.addr_fill <= FILL_W'(BUF_DEPTH)))
		else $error("buffer fill level beyond depth");

	// in-band restart brings both fill levels back to one and address entry 0 to the restart word
	a_restart_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fetch.restart) |=>
			(state_q.insn_fill == FILL_W'(1) && state_q.addr_fill == FILL_W'(1)
			&& state_q.addr[0] == ADDR_RESTART))
		else $error("restart did not reset fill levels");

	// an accepted item always produces a pending result
	a_result_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item left no result");

endmodule

`default_nettype wire

@@ tb/prefetch_checker.sv @@
// status checker for the instruction prefetch buffer: follows both channels,
// predicts every status item from the accepted fetch items and compares them
// depends on ipb_pkg
`default_nettype none

module prefetch_checker
	import ipb_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          fetch_valid,
	input  wire          fetch_stall,
	input  wire fetch_item_t  fetch,
	input  wire          status_valid,
	input  wire          status_stall,
	input  wire status_item_t status,
	output int           failures,
	output int           outstanding
);

	localparam int MAX_REPORTS = 10;

	// care holds ones where the value is defined; entries never written are not checked
	typedef struct {
		status_item_t value;
		status_item_t care;
	} expectation_t;

	logic [WORD_W-1:0] insn_mem [BUF_DEPTH];
	logic [WORD_W-1:0] addr_mem [BUF_DEPTH];
	bit                insn_set [BUF_DEPTH];
	bit                addr_set [BUF_DEPTH];
	int                insn_level;
	int                addr_level;
	bit                ack_seen;
	logic [WORD_W-1:0] read_addr;
	bit                read_addr_set;

	expectation_t expected_status [$];
	expectation_t oldest;

	function automatic bit redirects(input logic [WORD_W-1:0] w);
		logic [5:0] op;
		op = w[WORD_W-1:WORD_W-6];
		return op <= OP_BRANCH_LAST || op == OP_JR || op == OP_JALR
			|| op == OP_MTHI || op == OP_MFLO;
	endfunction

	// one clock of the fetch unit; buffer updates read the values from before it, the result the new ones
	function automatic expectation_t predict_status(input fetch_item_t f);
		logic [WORD_W-1:0] oi [BUF_DEPTH];
		logic [WORD_W-1:0] oa [BUF_DEPTH];
		bit                oi_set [BUF_DEPTH];
		bit                oa_set [BUF_DEPTH];
		int                it, at, nit, src, adv, slot;
		bit                rd, rd_sure;
		expectation_t      e;

		for (int n = 0; n < BUF_DEPTH; n++) begin
			oi[n] = insn_mem[n];
			oa[n] = addr_mem[n];
			oi_set[n] = insn_set[n];
			oa_set[n] = addr_set[n];
		end
		it = insn_level;
		at = addr_level;
		adv = f.advance;

		if (f.advance) begin
			for (int n = 0; n + 1 < BUF_DEPTH; n++) begin
				insn_mem[n] = oi[n + 1];
				insn_set[n] = oi_set[n + 1];
				addr_mem[n] = oa[n + 1];
				addr_set[n] = oa_set[n + 1];
			end
			if (it > 0) it--;
			if (at > 0) at--;
		end

		if (at < BUF_DEPTH) begin
			src = f.advance ? at : (at > 0 ? at - 1 : 0);
			addr_mem[at] = oa[src] + ADDR_STEP;
			addr_set[at] = oa_set[src];
			at++;
		end

		if (f.take_jump) begin
			if (it > 2) it = 2;
			addr_mem[2] = f.jump_target;
			addr_set[2] = 1'b1;
			at = 3;
		end

		if (ack_seen && it < BUF_DEPTH) begin
			insn_mem[it] = f.mem_data;
			insn_set[it] = 1'b1;
			it++;
		end
		ack_seen = f.mem_ack;

		rd = 1'b0;
		rd_sure = 1'b1;
		nit = it + int'(f.mem_ack);
		if (at > nit && nit + adv < BUF_DEPTH) begin
			rd = 1'b1;
			if (nit >= 2) begin
				slot = nit + adv - 2;
				if (!oi_set[slot])
					rd_sure = 1'b0;
				else
					rd = !redirects(oi[slot]);
			end
			if (!rd_sure)
				read_addr_set = 1'b0;
			else if (rd) begin
				read_addr = oa[nit + adv];
				read_addr_set = oa_set[nit + adv];
			end
		end

		if (f.restart) begin
			it = 1;
			addr_mem[0] = ADDR_RESTART;
			addr_set[0] = 1'b1;
			at = 1;
			rd = 1'b0;
			rd_sure = 1'b1;
		end

		insn_level = it;
		addr_level = at;

		e.value = '0;
		e.care = '0;
		e.value.read_request = rd;
		e.care.read_request = rd_sure;
		e.value.read_address = read_addr;
		e.care.read_address = {WORD_W{read_addr_set}};
		e.value.current_insn = insn_mem[1];
		e.care.current_insn = {WORD_W{insn_set[1]}};
		e.value.insn_valid = insn_level > 1;
		e.care.insn_valid = 1'b1;
		e.value.prev_pc = addr_mem[0];
		e.care.prev_pc = {WORD_W{addr_set[0]}};
		e.value.cur_pc = addr_mem[1];
		e.care.cur_pc = {WORD_W{addr_set[1]}};
		e.value.next_pc = addr_mem[2];
		e.care.next_pc = {WORD_W{addr_set[2]}};
		e.value.next_pc_valid = addr_level > 2;
		e.care.next_pc_valid = 1'b1;
		return e;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got, input logic [WORD_W-1:0] care);
		if (((got ^ want) & care) !== '0) begin
			failures++;
			if (failures <= MAX_REPORTS)
				$display("status %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < BUF_DEPTH; n++) begin
				insn_mem[n] = '0;
				addr_mem[n] = '0;
				insn_set[n] = 1'b0;
				addr_set[n] = 1'b0;
			end
			addr_mem[0] = ADDR_RESTART;
			addr_set[0] = 1'b1;
			insn_level = 1;
			addr_level = 1;
			ack_seen = 1'b0;
			read_addr = '0;
			read_addr_set = 1'b1;
			expected_status.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			if (status_valid && !status_stall) begin
				if (expected_status.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("status item %h with none expected", status);
				end else begin
					oldest = expected_status.pop_front();
					check_field("read_request", oldest.value.read_request,
						status.read_request, oldest.care.read_request);
					check_field("read_address", oldest.value.read_address,
						status.read_address, oldest.care.read_address);
					check_field("current_insn", oldest.value.current_insn,
						status.current_insn, oldest.care.current_insn);
					check_field("insn_valid", oldest.value.insn_valid,
						status.insn_valid, oldest.care.insn_valid);
					check_field("prev_pc", oldest.value.prev_pc,
						status.prev_pc, oldest.care.prev_pc);
					check_field("cur_pc", oldest.value.cur_pc,
						status.cur_pc, oldest.care.cur_pc);
					check_field("next_pc", oldest.value.next_pc,
						status.next_pc, oldest.care.next_pc);
					check_field("next_pc_valid", oldest.value.next_pc_valid,
						status.next_pc_valid, oldest.care.next_pc_valid);
				end
			end
			if (fetch_valid && !fetch_stall)
				expected_status.push_back(predict_status(fetch));
			outstanding = expected_status.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/instruction_prefetch_buffer_test.sv @@
// top of the instruction prefetch buffer regression: clock, reset, fetch items and
// status stalls, watchdog and verdict
// depends on ipb_pkg, instruction_prefetch_buffer and prefetch_checker
`default_nettype none

module instruction_prefetch_buffer_test;
	import ipb_pkg::*;

	localparam int QUIET_LIMIT   = 2000; // cycles with no item moving on either channel
	localparam int SETTLE_CYCLES = 10;   // wait before the verdict, after the final drain
	localparam int RESET_CYCLES  = 6;
	localparam int JUMP_PCT      = 8;
	localparam int ALIGNED_PCT   = 85;
	localparam int JUMP_OP_PCT   = 25;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         fetch_valid = 1'b0;
	logic         fetch_stall;
	fetch_item_t  fetch = '0;
	logic         status_valid;
	logic         status_stall = 1'b0;
	status_item_t status;

	int send_idle = 0;
	int recv_idle = 0;
	int quiet = 0;
	int failures;
	int outstanding;

	instruction_prefetch_buffer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.fetch_valid  (fetch_valid),
		.fetch_stall  (fetch_stall),
		.fetch        (fetch),
		.status_valid (status_valid),
		.status_stall (status_stall),
		.status       (status)
	);

	prefetch_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.fetch_valid  (fetch_valid),
		.fetch_stall  (fetch_stall),
		.fetch        (fetch),
		.status_valid (status_valid),
		.status_stall (status_stall),
		.status       (status),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always #5 clk = ~clk;

	// status side stalls at random, a fresh decision every cycle
	always @(negedge clk) begin
		status_stall <= ($urandom_range(99) < recv_idle);
	end

	// watchdog: a run that stops moving items for too long is a failure
	always @(posedge clk) begin
		if (!arst_n || (fetch_valid && !fetch_stall) || (status_valid && !status_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("instruction_prefetch_buffer regression: fail");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the item was taken;
	// valid stays high from one item to the next when no idle cycle is drawn
	task automatic send_item(input fetch_item_t item);
		while ($urandom_range(99) < send_idle) begin
			fetch_valid <= 1'b0;
			@(negedge clk);
		end
		fetch_valid <= 1'b1;
		fetch       <= item;
		do @(posedge clk); while (fetch_stall !== 1'b0);
		@(negedge clk);
	endtask

	// hold the fetch side until every predicted status item has come back
	task automatic drain();
		fetch_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	function automatic fetch_item_t make_item(input bit adv, input bit jmp,
			input logic [WORD_W-1:0] target, input bit ack,
			input logic [WORD_W-1:0] data, input bit rst);
		fetch_item_t f;
		f.advance     = adv;
		f.take_jump   = jmp;
		f.jump_target = target;
		f.mem_ack     = ack;
		f.mem_data    = data;
		f.restart     = rst;
		return f;
	endfunction

	function automatic logic [WORD_W-1:0] word_with_op(input logic [5:0] op);
		logic [WORD_W-1:0] w;
		w = $urandom;
		w[WORD_W-1:WORD_W-6] = op;
		return w;
	endfunction

	// instruction word; with jump_pct percent chance its opcode holds back prefetch
	function automatic logic [WORD_W-1:0] random_word(input int jump_pct);
		logic [WORD_W-1:0] w;
		w = $urandom;
		if ($urandom_range(99) < jump_pct) begin
			case ($urandom_range(4))
				0: w = word_with_op(6'($urandom_range(OP_BRANCH_LAST)));
				1: w = word_with_op(OP_JR);
				2: w = word_with_op(OP_JALR);
				3: w = word_with_op(OP_MTHI);
				default: w = word_with_op(OP_MFLO);
			endcase
		end
		return w;
	endfunction

	function automatic fetch_item_t random_item(input int adv_pct, input int ack_pct);
		fetch_item_t f;
		f.advance     = ($urandom_range(99) < adv_pct);
		f.take_jump   = ($urandom_range(99) < JUMP_PCT);
		f.jump_target = $urandom;
		if ($urandom_range(99) < ALIGNED_PCT)
			f.jump_target[1:0] = 2'b00;
		if ($urandom_range(19) == 0)
			f.jump_target = $urandom_range(1) ? 32'hFFFF_FFFC : 32'h0;
		f.mem_ack     = ($urandom_range(99) < ack_pct);
		f.mem_data    = random_word(JUMP_OP_PCT);
		f.restart     = ($urandom_range(199) == 0);
		return f;
	endfunction

	// bursts with their own advance and ack rates, so the fill levels swing
	// between empty and full; one drain in the middle of each phase
	task automatic random_phase(input int count);
		int adv_pct, ack_pct, left;
		left = 0;
		adv_pct = 50;
		ack_pct = 50;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				left    = $urandom_range(60, 15);
				adv_pct = $urandom_range(90, 10);
				ack_pct = $urandom_range(95, 20);
			end
			if (n == count / 2)
				drain();
			send_item(random_item(adv_pct, ack_pct));
			left--;
		end
	endtask

	task automatic directed_items();
		// every redirecting opcode, more words than the buffer holds
		for (int op = 0; op <= OP_BRANCH_LAST; op++)
			send_item(make_item(0, 0, '0, 1, word_with_op(op[5:0]), 0));
		send_item(make_item(0, 0, '0, 1, word_with_op(OP_JR), 0));
		send_item(make_item(0, 0, '0, 1, word_with_op(OP_JALR), 0));
		send_item(make_item(0, 0, '0, 1, word_with_op(OP_MTHI), 0));
		send_item(make_item(0, 0, '0, 1, word_with_op(OP_MFLO), 0));
		// word arriving into a full buffer is dropped
		send_item(make_item(0, 0, '0, 1, '1, 0));
		send_item(make_item(0, 0, '0, 0, '0, 0));
		send_item(make_item(1, 0, '0, 0, '0, 0));
		// jumps to both ends of the address space and to an odd address
		send_item(make_item(1, 1, '0, 0, '0, 0));
		send_item(make_item(1, 1, 32'hFFFF_FFFC, 1, random_word(0), 0));
		send_item(make_item(0, 1, 32'h1234_5677, 1, random_word(0), 0));
		for (int n = 0; n < 3; n++)
			send_item(make_item(1, 0, '0, 1, random_word(0), 0));
		// restart together with everything else, then alone
		send_item(make_item(1, 1, '1, 1, '1, 1));
		send_item(make_item(0, 0, '0, 0, '0, 1));
		for (int n = 0; n < 3; n++)
			send_item(make_item(0, 0, '0, 1, random_word(0), 0));
		send_item(make_item(1, 0, '0, 0, '0, 0));
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles a quarter of the time, receiver stalls most of it
		send_idle = 25;
		recv_idle = 64;
		directed_items();
		drain();
		random_phase(220);
		drain();

		// the other way round
		send_idle = 64;
		recv_idle = 25;
		random_phase(220);
		drain();

		// full rate on both sides
		send_idle = 0;
		recv_idle = 0;
		random_phase(210);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("instruction_prefetch_buffer regression: pass");
		else
			$display("instruction_prefetch_buffer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
sv/ipb_pkg.sv
sv/ipb_next.sv
sv/instruction_prefetch_buffer.sv
tb/prefetch_checker.sv
tb/instruction_prefetch_buffer_test.sv
